// ===== design/ifrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ifrc_pkg
// Shared types, register indexes and codes for the flip/rotate/color engine.
// ----------------------------------------------------------------------------
package ifrc_pkg;

  // Register file
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GEOMETRY_MODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_OP      = 2'd3;

  // Field widths
  localparam int DIM_W   = 9;   // image size and mapped coordinates
  localparam int COORD_W = 8;   // row/col of an input word
  localparam int BYTE_W  = 8;
  localparam int PIXEL_W = 3 * BYTE_W;
  localparam int CLAMP_W = 13;  // holds the largest supported maximum size
  localparam int MODE_W  = 3;
  localparam int SUM_W   = 10;  // sum of three bytes

  // Geometry codes
  localparam logic [MODE_W-1:0] GEO_NONE       = 3'd0;
  localparam logic [MODE_W-1:0] GEO_FLIP_H     = 3'd1;
  localparam logic [MODE_W-1:0] GEO_FLIP_V     = 3'd2;
  localparam logic [MODE_W-1:0] GEO_ROT_LEFT   = 3'd3;
  localparam logic [MODE_W-1:0] GEO_ROT_RIGHT  = 3'd4;
  localparam logic [MODE_W-1:0] GEO_ROT_180    = 3'd5;

  // Color codes
  localparam logic [MODE_W-1:0] COLOR_NONE     = 3'd0;
  localparam logic [MODE_W-1:0] COLOR_GREY     = 3'd1;
  localparam logic [MODE_W-1:0] COLOR_ZERO_B2  = 3'd2;
  localparam logic [MODE_W-1:0] COLOR_ZERO_B1  = 3'd3;
  localparam logic [MODE_W-1:0] COLOR_ZERO_B0  = 3'd4;

  localparam logic [CLAMP_W-1:0] RESET_DIM = 13'd256;

  // Reciprocal for floor(x / 3), exact for x <= 765
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int DIV3_PROD_W = SUM_W + 10;

  typedef struct packed {
    logic capture;  // register an accepted word
    logic access;   // memory write or read
    logic load;     // fill the output register
  } ifrc_cmd_t;

  typedef struct packed {
    logic is_read;  // captured word is a read
  } ifrc_stat_t;

  function automatic logic [BYTE_W-1:0] div3(input logic [SUM_W-1:0] x);
    logic [DIV3_PROD_W-1:0] prod;
    prod = DIV3_PROD_W'(x) * DIV3_PROD_W'(DIV3_MUL);
    return BYTE_W'(prod >> DIV3_SHIFT);
  endfunction

endpackage

// ===== design/ifrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ifrc_ctrl
// Sequencer: capture, memory access, output load; owns the output valid flag.
// ----------------------------------------------------------------------------
module ifrc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ifrc_pkg::ifrc_cmd_t  cmd_o,
  input  ifrc_pkg::ifrc_stat_t stat_i
);
  import ifrc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_LOAD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // output register can take a new word if empty or drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.access  = 1'b0;
    cmd_o.load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd_o.access = 1'b1;
        state_d      = stat_i.is_read ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/ifrc_datapath.sv =====
// ----------------------------------------------------------------------------
// ifrc_datapath
// Registers, coordinate mapping, pixel store and color step.
// ----------------------------------------------------------------------------
module ifrc_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ifrc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ifrc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                func_i,
  input  logic [ifrc_pkg::COORD_W-1:0]        row_i,
  input  logic [ifrc_pkg::COORD_W-1:0]        col_i,
  input  logic [ifrc_pkg::BYTE_W-1:0]         pixel_byte0_i,
  input  logic [ifrc_pkg::BYTE_W-1:0]         pixel_byte1_i,
  input  logic [ifrc_pkg::BYTE_W-1:0]         pixel_byte2_i,
  output logic [ifrc_pkg::BYTE_W-1:0]         out_byte0_o,
  output logic [ifrc_pkg::BYTE_W-1:0]         out_byte1_o,
  output logic [ifrc_pkg::BYTE_W-1:0]         out_byte2_o,
  output logic                                out_of_range_o,
  input  ifrc_pkg::ifrc_cmd_t                 cmd_i,
  output ifrc_pkg::ifrc_stat_t                stat_o
);
  import ifrc_pkg::*;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [CLAMP_W-1:0] MAX_W_C    = CLAMP_W'(MAX_WIDTH);
  localparam logic [CLAMP_W-1:0] MAX_H_C    = CLAMP_W'(MAX_HEIGHT);
  localparam logic [ADDR_W-1:0]  ROW_STRIDE = ADDR_W'(MAX_WIDTH);

  // configuration
  logic [DIM_W-1:0]  width_q, height_q;
  logic [MODE_W-1:0] geo_q, color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(RESET_DIM);
      height_q <= DIM_W'(RESET_DIM);
      geo_q    <= GEO_NONE;
      color_q  <= COLOR_NONE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:   width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT:  height_q <= cfg_wdata_i;
        CFG_GEOMETRY_MODE: geo_q    <= cfg_wdata_i[MODE_W-1:0];
        CFG_COLOR_OP:      color_q  <= cfg_wdata_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective size, clamped to the store
  logic [DIM_W-1:0] w, h, out_rows, out_cols, r, c, sr, sc;
  logic             rotated, rd_oor, wr_ok;

  always_comb begin
    w = ({{(CLAMP_W-DIM_W){1'b0}}, width_q} > MAX_W_C) ? MAX_W_C[DIM_W-1:0] : width_q;
    h = ({{(CLAMP_W-DIM_W){1'b0}}, height_q} > MAX_H_C) ? MAX_H_C[DIM_W-1:0] : height_q;
    r = DIM_W'(row_i);
    c = DIM_W'(col_i);
    rotated  = (geo_q == GEO_ROT_LEFT) || (geo_q == GEO_ROT_RIGHT);
    out_rows = rotated ? w : h;
    out_cols = rotated ? h : w;
    rd_oor   = (r >= out_rows) || (c >= out_cols);
    wr_ok    = (r < h) && (c < w);

    sr = r;
    sc = c;
    if (func_i) begin
      case (geo_q)
        GEO_FLIP_H:    begin sr = r;             sc = w - 9'd1 - c; end
        GEO_FLIP_V:    begin sr = h - 9'd1 - r;  sc = c;            end
        GEO_ROT_LEFT:  begin sr = h - 9'd1 - c;  sc = r;            end
        GEO_ROT_RIGHT: begin sr = c;             sc = w - 9'd1 - r; end
        GEO_ROT_180:   begin sr = h - 9'd1 - r;  sc = w - 9'd1 - c; end
        default:       begin sr = r;             sc = c;            end
      endcase
    end
  end

  // captured word
  logic               is_read_q, oor_q, wr_ok_q;
  logic [DIM_W-1:0]   sr_q, sc_q;
  logic [PIXEL_W-1:0] px_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_read_q <= 1'b0;
      oor_q     <= 1'b0;
      wr_ok_q   <= 1'b0;
    end else if (cmd_i.capture) begin
      is_read_q <= func_i;
      oor_q     <= func_i && rd_oor;
      wr_ok_q   <= !func_i && wr_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sr_q <= sr;
      sc_q <= sc;
      px_q <= {pixel_byte2_i, pixel_byte1_i, pixel_byte0_i};
    end
  end

  assign stat_o.is_read = is_read_q;

  // pixel store
  logic [ADDR_W-1:0]  addr;
  logic [PIXEL_W-1:0] store [STORE_DEPTH];
  logic [PIXEL_W-1:0] rdata_q;

  assign addr = ADDR_W'(sr_q) * ROW_STRIDE + ADDR_W'(sc_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.access && wr_ok_q) store[addr] <= px_q;
    if (cmd_i.access && is_read_q && !oor_q) rdata_q <= store[addr];
  end

  // color step
  logic [BYTE_W-1:0] b0, b1, b2, grey;
  logic [SUM_W-1:0]  sum;

  always_comb begin
    b0   = rdata_q[BYTE_W-1:0];
    b1   = rdata_q[2*BYTE_W-1:BYTE_W];
    b2   = rdata_q[PIXEL_W-1:2*BYTE_W];
    sum  = SUM_W'(b0) + SUM_W'(b1) + SUM_W'(b2);
    grey = div3(sum);
    case (color_q)
      COLOR_GREY:    begin b0 = grey; b1 = grey; b2 = grey; end
      COLOR_ZERO_B2: b2 = '0;
      COLOR_ZERO_B1: b1 = '0;
      COLOR_ZERO_B0: b0 = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_byte0_o    <= oor_q ? '0 : b0;
      out_byte1_o    <= oor_q ? '0 : b1;
      out_byte2_o    <= oor_q ? '0 : b2;
      out_of_range_o <= oor_q;
    end
  end

endmodule

// ===== design/image_flip_rotate_color_engine_top.sv =====
// ----------------------------------------------------------------------------
// image_flip_rotate_color_engine_top
// Frame store with flip/rotate mapping and a color step on read-out.
//
//   port group    direction  handshake               payload
//   in            in         in_valid_i / in_stall_o func, row, col, pixel bytes
//   out           out        out_valid_o/out_stall_i out bytes, out_of_range
//   cfg           in         cfg_we_i                cfg_index_i, cfg_wdata_i
//
// A write word steps through capture and store write; a read word through capture,
// store read and output load, set by the single store port and the sequencer.
// The output register holds a read result while the next word is accepted; a
// stalled result delays the load of the following read, and input stalls meanwhile.
// Reset clears control and configuration; the store is not cleared.
// ----------------------------------------------------------------------------
module image_flip_rotate_color_engine_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ifrc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ifrc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            func_i,
  input  logic [ifrc_pkg::COORD_W-1:0]    row_i,
  input  logic [ifrc_pkg::COORD_W-1:0]    col_i,
  input  logic [ifrc_pkg::BYTE_W-1:0]     pixel_byte0_i,
  input  logic [ifrc_pkg::BYTE_W-1:0]     pixel_byte1_i,
  input  logic [ifrc_pkg::BYTE_W-1:0]     pixel_byte2_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ifrc_pkg::BYTE_W-1:0]     out_byte0_o,
  output logic [ifrc_pkg::BYTE_W-1:0]     out_byte1_o,
  output logic [ifrc_pkg::BYTE_W-1:0]     out_byte2_o,
  output logic                            out_of_range_o
);
  import ifrc_pkg::*;

  ifrc_cmd_t  cmd;
  ifrc_stat_t stat;

  ifrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  ifrc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .func_i         (func_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .pixel_byte0_i  (pixel_byte0_i),
    .pixel_byte1_i  (pixel_byte1_i),
    .pixel_byte2_i  (pixel_byte2_i),
    .out_byte0_o    (out_byte0_o),
    .out_byte1_o    (out_byte1_o),
    .out_byte2_o    (out_byte2_o),
    .out_of_range_o (out_of_range_o),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule
